[hw/rtl/ethernet_tx_framer_with_padding_assert.svh]
// ----------------------------------------------------------------------------
// ethernet tx framer assertion macros
// implication and never-true checks, clocked on the rising edge, off in reset
// ----------------------------------------------------------------------------
`ifndef ETHERNET_TX_FRAMER_WITH_PADDING_ASSERT_SVH
`define ETHERNET_TX_FRAMER_WITH_PADDING_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ETF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("etf implication check failed");

// condition must never hold
`define ETF_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("etf never check failed");

`endif

[hw/rtl/etf_pkg.sv]
// ----------------------------------------------------------------------------
// etf_pkg
// constants, types and helpers shared by the ethernet tx framer
// ----------------------------------------------------------------------------
`default_nettype none

package etf_pkg;

   localparam int MIN_FRAME_BYTES   = 60;
   localparam int MAX_PAYLOAD_BYTES = 1500;
   localparam int HDR_BYTES         = 14;
   localparam int MAC_W             = 48;
   localparam int TYPE_W            = 16;
   localparam int BYTE_W            = 8;
   localparam int HDR_W             = 2 * MAC_W + TYPE_W;

   localparam int CNT_W     = $clog2(HDR_BYTES + MAX_PAYLOAD_BYTES + 1);
   localparam int PAD_W     = $clog2(MIN_FRAME_BYTES + 1);
   localparam int HDR_IDX_W = $clog2(HDR_BYTES);

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [CNT_W-1:0]     CNT_HDR   = CNT_W'(HDR_BYTES);
   localparam logic [CNT_W-1:0]     CNT_LIMIT = CNT_W'(HDR_BYTES + MAX_PAYLOAD_BYTES);
   localparam logic [CNT_W-1:0]     CNT_MIN   = CNT_W'(MIN_FRAME_BYTES);
   localparam logic [HDR_IDX_W-1:0] HDR_IDX_END = HDR_IDX_W'(HDR_BYTES - 1);

   // one queued word: what the back end has to send for one accepted byte
   typedef struct packed {
      logic [MAC_W-1:0]  dest;
      logic [TYPE_W-1:0] etype;
      logic [BYTE_W-1:0] data;
      logic              hdr;
      logic              last;
      logic              ovf;
      logic [PAD_W-1:0]  pad;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HDR,
      BK_BYTE,
      BK_PAD
   } back_state_type;

   // header byte idx, destination first, most significant byte first
   function automatic logic [BYTE_W-1:0] hdr_byte(input logic [MAC_W-1:0]     dest,
                                                 input logic [MAC_W-1:0]     src,
                                                 input logic [TYPE_W-1:0]    etype,
                                                 input logic [HDR_IDX_W-1:0] idx);
      logic [HDR_W-1:0] hdr_vec;
      hdr_vec  = {dest, src, etype};
      hdr_byte = hdr_vec[(HDR_W - 1) - BYTE_W * int'(idx) -: BYTE_W];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/etf_front.sv]
// ----------------------------------------------------------------------------
// etf_front
// tracks frame position per accepted byte, decides drop and padding length
// ----------------------------------------------------------------------------
`default_nettype none

module etf_front
   import etf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [MAC_W-1:0]  dest,
   input  wire logic [TYPE_W-1:0] etype,
   input  wire logic [BYTE_W-1:0] data,
   input  wire logic              last,
   output logic                   push,
   output cmd_type                cmd
);

   logic             open_ff, open_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;

   logic [CNT_W-1:0] cnt_base, cnt_nx;
   logic             ovf_base, ovf_nx, keep;

   always_comb begin
      cnt_base = open_ff ? cnt_ff : CNT_HDR;
      ovf_base = open_ff & ovf_ff;
      keep     = cnt_base < CNT_LIMIT;
      cnt_nx   = cnt_base + CNT_W'(keep);
      ovf_nx   = ovf_base | ~keep;

      open_in = open_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      if (accept) begin
         open_in = ~last;
         cnt_in  = last ? '0 : cnt_nx;
         ovf_in  = ~last & ovf_nx;
      end

      // a dropped non-final byte produces nothing downstream
      push      = accept & (keep | last);
      cmd.dest  = dest;
      cmd.etype = etype;
      cmd.data  = keep ? data : '0;
      cmd.hdr   = ~open_ff;
      cmd.last  = last;
      cmd.ovf   = ovf_nx;
      cmd.pad   = (last && cnt_nx < CNT_MIN) ? PAD_W'(CNT_MIN - cnt_nx) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         open_ff <= open_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/etf_queue.sv]
// ----------------------------------------------------------------------------
// etf_queue
// small first-in first-out buffer of command words between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module etf_queue
   import etf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   input  wire logic pop,
   output logic      full,
   output logic      not_empty,
   output cmd_type   head
);

   cmd_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = count_ff == QCNT_W'(QDEPTH);
      not_empty = count_ff != '0;
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/etf_back.sv]
// ----------------------------------------------------------------------------
// etf_back
// plays out each command word: the header first if it opens a frame, then its payload byte, then any padding
// ----------------------------------------------------------------------------
`default_nettype none

module etf_back
   import etf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [MAC_W-1:0]  src_addr,
   input  wire logic              q_not_empty,
   input  cmd_type                q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [BYTE_W-1:0]      rsp_frame_byte,
   output logic                   rsp_frame_last,
   output logic                   rsp_oversize_error
);

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   logic [PAD_W-1:0]     pad_ff, pad_in;

   logic                 valid_ff, valid_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 err_ff, err_in;

   logic adv, emit, done;
   logic [BYTE_W-1:0] emit_byte;
   logic emit_last;

   always_comb begin
      adv       = ~valid_ff | rsp_ready;
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      pad_in    = pad_ff;
      emit      = 1'b0;
      done      = 1'b0;
      emit_byte = '0;
      emit_last = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            done = 1'b1;
         end
         BK_HDR: begin
            if (adv) begin
               emit      = 1'b1;
               emit_byte = hdr_byte(cmd_ff.dest, src_addr, cmd_ff.etype, idx_ff);
               idx_in    = idx_ff + 1'b1;
               if (idx_ff == HDR_IDX_END) begin
                  state_in = BK_BYTE;
               end
            end
         end
         BK_BYTE: begin
            if (adv) begin
               emit      = 1'b1;
               emit_byte = cmd_ff.data;
               if (cmd_ff.pad == '0) begin
                  done      = 1'b1;
                  emit_last = cmd_ff.last;
               end else begin
                  state_in = BK_PAD;
                  pad_in   = cmd_ff.pad;
               end
            end
         end
         BK_PAD: begin
            if (adv) begin
               emit   = 1'b1;
               pad_in = pad_ff - 1'b1;
               if (pad_ff == PAD_W'(1)) begin
                  done      = 1'b1;
                  emit_last = 1'b1;
               end
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase

      // chain straight into the next word so pass-through bytes need no gap
      q_pop = done & q_not_empty;
      if (done) begin
         if (q_not_empty) begin
            cmd_in   = q_head;
            idx_in   = '0;
            state_in = q_head.hdr ? BK_HDR : BK_BYTE;
         end else begin
            state_in = BK_IDLE;
         end
      end

      valid_in = emit | (valid_ff & ~rsp_ready);
      byte_in  = emit ? emit_byte : byte_ff;
      last_in  = emit ? emit_last : last_ff;
      err_in   = emit ? (emit_last & cmd_ff.ovf) : err_ff;

      rsp_valid          = valid_ff;
      rsp_frame_byte     = byte_ff;
      rsp_frame_last     = last_ff;
      rsp_oversize_error = err_ff;
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      pad_ff  <= pad_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/ethernet_tx_framer_with_padding.sv]
// ----------------------------------------------------------------------------
// ethernet_tx_framer_with_padding
// builds ethernet ii frames from a payload byte stream, padded to minimum size
// ----------------------------------------------------------------------------
// usage
//   req_* takes one payload byte per word with a last mark; destination and
//   type are sampled on the first word of each frame. rsp_* gives one frame
//   byte per word: 14 header bytes before the first payload byte, zero pad
//   bytes after the last one up to the minimum frame size. bytes past the
//   payload limit are dropped and oversize_error is raised on the final byte.
//   csr_write_enable loads the station address; write it only while idle.
//   with the output idle, an accepted word goes into the queue, is loaded
//   into the sequencer and is then registered onto rsp_valid, for the first
//   header byte and for a mid-frame byte alike. one output word per cycle
//   while rsp_ready is high; an input word costs one output word per frame
//   byte it brings, header and pad included, set by the single byte-wide sequencer.
//   a 4-word command queue lets input keep flowing while the output stalls.
//   reset empties the queue, closes any open frame and clears the address;
//   a stalled receiver holds the output word and fills the queue, then
//   req_ready drops until space frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_tx_framer_with_padding
   import etf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [MAC_W-1:0]  csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [MAC_W-1:0]  req_destination_address,
   input  wire logic [TYPE_W-1:0] req_ether_type,
   input  wire logic [BYTE_W-1:0] req_payload_byte,
   input  wire logic              req_payload_last,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [BYTE_W-1:0]      rsp_frame_byte,
   output logic                   rsp_frame_last,
   output logic                   rsp_oversize_error
);

`include "ethernet_tx_framer_with_padding_assert.svh"

   logic [MAC_W-1:0] source_address_ff, source_address_in;

   logic    accept, q_push, q_pop, q_full, q_not_empty;
   cmd_type push_cmd, q_head;

   always_comb begin
      req_ready         = ~q_full;
      accept            = req_valid & req_ready;
      source_address_in = csr_write_enable ? csr_write_data : source_address_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_address_ff <= '0;
      end else begin
         source_address_ff <= source_address_in;
      end
   end

   etf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .dest   (req_destination_address),
      .etype  (req_ether_type),
      .data   (req_payload_byte),
      .last   (req_payload_last),
      .push   (q_push),
      .cmd    (push_cmd)
   );

   etf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   etf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .src_addr           (source_address_ff),
      .q_not_empty        (q_not_empty),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_oversize_error (rsp_oversize_error)
   );

   `ETF_ASSERT_NEVER(a_no_push_when_full, clock, reset, q_push && q_full)
   `ETF_ASSERT_NEVER(a_no_pop_when_empty, clock, reset, q_pop && !q_not_empty)
   `ETF_ASSERT_IMPL(a_err_only_on_last, clock, reset, rsp_valid && rsp_oversize_error, rsp_frame_last)
   `ETF_ASSERT_IMPL(a_push_needs_accept, clock, reset, q_push, req_valid && req_ready)

endmodule

`default_nettype wire

[test/ethernet_tx_framer_with_padding_tb.sv]
// ----------------------------------------------------------------------------
// ethernet_tx_framer_with_padding_tb
// self-checking bench for the tx framer: payload words go in with random gaps
// and the output is stalled at random. a local model predicts every frame
// byte (header, payload, zero padding, oversize cut and error flag) and each
// output word is checked in order against it
// ----------------------------------------------------------------------------
module ethernet_tx_framer_with_padding_tb;
   import etf_pkg::*;

   localparam int CYCLE_LIMIT  = 20000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_SHOWN    = 10;
   localparam int MAC_BYTES    = MAC_W / BYTE_W;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              ovf;
   } frame_word_type;

   logic              clock                   = 1'b0;
   logic              reset                   = 1'b1;
   logic              csr_write_enable        = 1'b0;
   logic [MAC_W-1:0]  csr_write_data          = '0;
   logic              req_valid               = 1'b0;
   logic              req_ready;
   logic [MAC_W-1:0]  req_destination_address = '0;
   logic [TYPE_W-1:0] req_ether_type          = '0;
   logic [BYTE_W-1:0] req_payload_byte        = '0;
   logic              req_payload_last        = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready               = 1'b0;
   logic [BYTE_W-1:0] rsp_frame_byte;
   logic              rsp_frame_last;
   logic              rsp_oversize_error;

   // model state
   logic [MAC_W-1:0] station_address = '0;
   logic             frame_open      = 1'b0;
   logic [10:0]      frame_count     = '0;
   logic             frame_cut       = 1'b0;
   frame_word_type   frame_words_q[$];

   int             error_count = 0;
   int             cycle_count = 0;
   bit             req_live    = 1'b0;
   bit             req_no_gaps = 1'b0;
   bit             rsp_no_gaps = 1'b0;
   int             hold_asked  = 0;
   int             hold_taken  = 0;
   int             hold_left   = 0;
   int             stall_left  = 0;
   frame_word_type want_word;

   ethernet_tx_framer_with_padding u_top (
      .clock                   (clock),
      .reset                   (reset),
      .csr_write_enable        (csr_write_enable),
      .csr_write_data          (csr_write_data),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_destination_address (req_destination_address),
      .req_ether_type          (req_ether_type),
      .req_payload_byte        (req_payload_byte),
      .req_payload_last        (req_payload_last),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_frame_byte          (rsp_frame_byte),
      .rsp_frame_last          (rsp_frame_last),
      .rsp_oversize_error      (rsp_oversize_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void flag_error(input string msg);
      if (error_count < MAX_SHOWN) begin
         $display("%s", msg);
      end
      error_count++;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(input bit no_gaps);
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic void push_frame_byte(input logic [BYTE_W-1:0] b);
      frame_words_q.push_back('{data: b, last: 1'b0, ovf: 1'b0});
   endfunction

   // expected frame bytes caused by one accepted payload word
   function automatic void predict_frame(input logic [MAC_W-1:0]  dest,
                                         input logic [TYPE_W-1:0] etype,
                                         input logic [BYTE_W-1:0] data,
                                         input logic              last);
      int produced;
      int i;
      produced = 0;
      if (!frame_open) begin
         for (i = 0; i < MAC_BYTES; i++) begin
            push_frame_byte(dest[MAC_W-1-BYTE_W*i -: BYTE_W]);
         end
         for (i = 0; i < MAC_BYTES; i++) begin
            push_frame_byte(station_address[MAC_W-1-BYTE_W*i -: BYTE_W]);
         end
         push_frame_byte(etype[TYPE_W-1 -: BYTE_W]);
         push_frame_byte(etype[BYTE_W-1:0]);
         produced    = HDR_BYTES;
         frame_count = 11'(HDR_BYTES);
         frame_cut   = 1'b0;
         frame_open  = 1'b1;
      end
      if (frame_count < HDR_BYTES + MAX_PAYLOAD_BYTES) begin
         push_frame_byte(data);
         frame_count++;
         produced++;
      end else begin
         frame_cut = 1'b1;
      end
      if (last) begin
         while (frame_count < MIN_FRAME_BYTES) begin
            push_frame_byte('0);
            frame_count++;
            produced++;
         end
         // a dropped last byte still needs a closing marker word
         if (produced == 0) begin
            push_frame_byte('0);
         end
         frame_words_q[frame_words_q.size()-1].last = 1'b1;
         frame_words_q[frame_words_q.size()-1].ovf  = frame_cut;
         frame_open  = 1'b0;
         frame_count = '0;
         frame_cut   = 1'b0;
      end
   endfunction

   task automatic send_word(input logic [MAC_W-1:0]  dest,
                            input logic [TYPE_W-1:0] etype,
                            input logic [BYTE_W-1:0] data,
                            input logic              last);
      int gap;
      gap = pick_gap(req_no_gaps);
      if (gap > 0) begin
         if (req_live) begin
            req_valid <= 1'b0;
         end
         req_live = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_destination_address <= dest;
      req_ether_type          <= etype;
      req_payload_byte        <= data;
      req_payload_last        <= last;
      req_live = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_frame(dest, etype, data, last);
   endtask

   // later words carry random address and type as noise, which must be ignored
   task automatic send_frame(input int len);
      logic [MAC_W-1:0]  dest;
      logic [TYPE_W-1:0] etype;
      int i;
      for (i = 0; i < len; i++) begin
         dest  = MAC_W'({$urandom(), $urandom()});
         etype = TYPE_W'($urandom());
         send_word(dest, etype, BYTE_W'($urandom()), i == len - 1);
      end
   endtask

   task automatic wait_idle();
      if (req_live) begin
         req_valid <= 1'b0;
      end
      req_live = 1'b0;
      while (frame_words_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_station_address(input logic [MAC_W-1:0] addr);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= addr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      station_address = addr;
   endtask

   task automatic test_header_extremes();
      // address still at its reset value
      send_word('0, '0, '0, 1'b1);
      write_station_address('1);
      send_word('1, '1, '1, 1'b1);
      write_station_address('0);
      send_word(48'h0123_4567_89ab, 16'h0800, 8'h5a, 1'b1);
      send_word(48'h8000_0000_0001, 16'h8001, 8'h81, 1'b1);
   endtask

   task automatic test_short_frames();
      send_word(48'h0000_ffff_0000, 16'h00ff, 8'h00, 1'b0);
      send_word(48'hffff_0000_ffff, 16'hff00, 8'hff, 1'b1);
      send_frame(3);
      send_frame(2);
   endtask

   // fills the payload to the limit, then drops a middle and a last byte
   task automatic test_payload_limit();
      write_station_address(MAC_W'({$urandom(), $urandom()}));
      req_no_gaps = 1'b1;
      send_frame(MAX_PAYLOAD_BYTES + 2);
      req_no_gaps = 1'b0;
   endtask

   // receiver holds off long enough for the command queue to fill
   task automatic test_back_pressure();
      wait_idle();
      hold_asked++;
      req_no_gaps = 1'b1;
      send_frame(12);
      send_frame(12);
      send_frame(12);
      req_no_gaps = 1'b0;
   endtask

   task automatic test_random_traffic(input int n_words);
      int sent;
      int len;
      int r;
      sent = 0;
      while (sent < n_words) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            len = $urandom_range(1, 8);
         end else if (r < 85) begin
            len = $urandom_range(9, 40);
         end else begin
            len = $urandom_range(43, 49);
         end
         send_frame(len);
         sent += len;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_words_q.size() == 0) begin
               flag_error($sformatf("unexpected word: byte %02h last %0b err %0b",
                                    rsp_frame_byte, rsp_frame_last, rsp_oversize_error));
            end else begin
               want_word = frame_words_q.pop_front();
               if (rsp_frame_byte !== want_word.data || rsp_frame_last !== want_word.last ||
                   rsp_oversize_error !== want_word.ovf) begin
                  flag_error($sformatf(
                     "mismatch: exp byte %02h last %0b err %0b, got byte %02h last %0b err %0b",
                     want_word.data, want_word.last, want_word.ovf,
                     rsp_frame_byte, rsp_frame_last, rsp_oversize_error));
               end
            end
         end
         if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_gap(rsp_no_gaps);
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_extremes();
      test_short_frames();
      test_payload_limit();
      test_back_pressure();
      // one stretch with no idling on either side
      wait_idle();
      req_no_gaps = 1'b1;
      rsp_no_gaps = 1'b1;
      test_random_traffic(20);
      wait_idle();
      req_no_gaps = 1'b0;
      rsp_no_gaps = 1'b0;
      write_station_address(MAC_W'({$urandom(), $urandom()}));
      test_random_traffic(30);
      write_station_address('1);
      test_random_traffic(30);
      write_station_address('0);
      test_random_traffic(30);
      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/etf_pkg.sv
hw/rtl/etf_front.sv
hw/rtl/etf_queue.sv
hw/rtl/etf_back.sv
hw/rtl/ethernet_tx_framer_with_padding.sv
test/ethernet_tx_framer_with_padding_tb.sv
